@@ rtl/kssd_pkg.sv @@
// ----------------------------------------------------------------------------
// kssd_pkg
// Scan phase codes, register map and segment glyph table for the keypad
// scanner with two-digit display.
// ----------------------------------------------------------------------------
`default_nettype none

package kssd_pkg;

	localparam int unsigned COLUMNS    = 8;
	localparam int unsigned COL_W      = $clog2(COLUMNS);
	localparam int unsigned PHASE_W    = 4;
	localparam int unsigned DIGIT_W    = 5;
	localparam int unsigned ADDR_W     = 3;

	localparam logic [PHASE_W-1:0] PH_SETTLE   = 4'd0;
	localparam logic [PHASE_W-1:0] PH_ROW_CONF = 4'd1;
	localparam logic [PHASE_W-1:0] PH_ROW_HOLD = 4'd2;
	localparam logic [PHASE_W-1:0] PH_ROW_POLL = 4'd3;
	localparam logic [PHASE_W-1:0] PH_ROW_REL  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_BTN_CONF = 4'd5;
	localparam logic [PHASE_W-1:0] PH_BTN_HOLD = 4'd6;
	localparam logic [PHASE_W-1:0] PH_BTN_POLL = 4'd7;
	localparam logic [PHASE_W-1:0] PH_BTN_REL  = 4'd8;

	localparam logic REG_SETTLE  = 1'b0;
	localparam logic REG_REFRESH = 1'b1;

	localparam logic [7:0]         SETTLE_RESET  = 8'd50;
	localparam logic [7:0]         REFRESH_RESET = 8'd10;
	localparam logic [DIGIT_W-1:0] BLANK_DIGIT   = 5'd10;
	localparam logic [7:0]         SEG_BLANK     = 8'hFF;
	localparam logic [7:0]         BTN_OFFSET    = 8'd60;

	localparam logic [1:0] SEL_NONE = 2'd0;
	localparam logic [1:0] SEL_HIGH = 2'd1;
	localparam logic [1:0] SEL_LOW  = 2'd2;

	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [DIGIT_W-1:0] digit_t;

	function automatic logic [7:0] glyph(input digit_t d);
		logic [7:0] g;
		case (d)
			5'd0:    g = 8'h03;
			5'd1:    g = 8'h9F;
			5'd2:    g = 8'h25;
			5'd3:    g = 8'h0D;
			5'd4:    g = 8'h99;
			5'd5:    g = 8'h49;
			5'd6:    g = 8'h41;
			5'd7:    g = 8'h1F;
			5'd8:    g = 8'h01;
			5'd9:    g = 8'h09;
			5'd11:   g = 8'hFE;
			5'd12:   g = 8'h11;
			5'd13:   g = 8'hC1;
			5'd14:   g = 8'h63;
			5'd15:   g = 8'h85;
			5'd16:   g = 8'h61;
			5'd17:   g = 8'h71;
			5'd18:   g = 8'h43;
			5'd19:   g = 8'h91;
			5'd20:   g = 8'hC3;
			5'd21:   g = 8'h83;
			5'd22:   g = 8'h73;
			5'd23:   g = 8'h13;
			5'd24:   g = 8'h31;
			5'd25:   g = 8'h89;
			default: g = SEG_BLANK;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

@@ rtl/keypad_scan_to_segment_display.sv @@
// ----------------------------------------------------------------------------
// keypad_scan_to_segment_display
// Eight-column key matrix and button scanner with debounce, key numbering
// and a two-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    main_rows, button_lines (one tick each)
//  out      out_valid / out_ready  column_drive, segment_pattern, digit_select,
//                                  key_code, key_held
//  cfg      APB write, pready = 1  settle_ticks @ 0x0, refresh_ticks @ 0x4
//
//  From input transfer to result: the input register, then one pass of
//  scan, digit split and glyph logic into the state/result registers.
//  One tick accepted per cycle while the result side keeps taking transfers.
//  A stalled result holds the state; the input register then holds too.
//  Reset clears all state to the idle scan of column zero, display blank.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_to_segment_display
	import kssd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,

	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        main_rows,
	input  wire logic [4:0]        button_lines,

	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [7:0]        column_drive,
	output logic      [7:0]        segment_pattern,
	output logic      [1:0]        digit_select,
	output logic      [7:0]        key_code,
	output logic                   key_held
);

	logic [7:0]       settle_q, refresh_cfg_q;

	logic             valid_s1;
	logic [7:0]       rows_s1;
	logic [4:0]       btns_s1;
	logic             adv;

	logic             out_valid_q;
	logic [COL_W-1:0] col_q;
	phase_t           phase_q;
	logic [7:0]       wait_q;
	logic [7:0]       code_q;
	digit_t           low_q, high_q;
	logic [7:0]       refresh_q;
	logic             dphase_q;
	logic [7:0]       seg_q;
	logic [1:0]       sel_q;

	logic [COL_W-1:0] col_d;
	phase_t           phase_d;
	logic [7:0]       wait_d;
	logic [7:0]       code_d;
	digit_t           low_d, high_d;
	logic [7:0]       refresh_d;
	logic             dphase_d;
	logic [7:0]       seg_d;
	logic [1:0]       sel_d;

	logic             rows_idle, btns_idle;
	logic [7:0]       wait_inc, refresh_inc;
	logic             wait_done;
	logic [6:0]       row_bits;
	logic [4:0]       btn_bits;
	logic             row_one, btn_one;
	logic [2:0]       row_idx, btn_idx;
	logic [7:0]       row_code, btn_code;
	logic [7:0]       col_ext;
	logic [15:0]      div_prod;
	logic [4:0]       div_q;
	logic [7:0]       div_r;
	logic             split;
	logic             cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_REFRESH) ? {24'd0, refresh_cfg_q} : {24'd0, settle_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q      <= SETTLE_RESET;
			refresh_cfg_q <= REFRESH_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_REFRESH) begin
				refresh_cfg_q <= pwdata[7:0];
			end else begin
				settle_q <= pwdata[7:0];
			end
		end
	end

	// handshake
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rows_s1 <= main_rows;
			btns_s1 <= button_lines;
		end
	end

	// key decode
	assign rows_idle = (rows_s1 == 8'hFF);
	assign btns_idle = (btns_s1 == 5'h1F);
	assign wait_inc  = wait_q + 8'd1;
	assign wait_done = (wait_inc >= settle_q);
	assign row_bits  = ~rows_s1[6:0];
	assign btn_bits  = ~btns_s1;
	assign row_one   = (row_bits != 7'd0) && ((row_bits & (row_bits - 7'd1)) == 7'd0);
	assign btn_one   = (btn_bits != 5'd0) && ((btn_bits & (btn_bits - 5'd1)) == 5'd0);
	assign col_ext   = {{(8-COL_W){1'b0}}, col_q};

	always_comb begin
		row_idx = 3'd0;
		for (int i = 0; i < 7; i++) begin
			if (row_bits[i]) row_idx = row_idx | 3'(i);
		end
		btn_idx = 3'd0;
		for (int i = 0; i < 5; i++) begin
			if (btn_bits[i]) btn_idx = btn_idx | 3'(i);
		end
	end

	assign row_code = (row_one ? {2'b00, row_idx, 3'b111} : code_q) - col_ext;
	assign btn_code = (btn_one ? {2'b00, btn_idx, 3'b000} : code_q) + col_ext + BTN_OFFSET;

	// scan sequencer
	always_comb begin
		col_d   = col_q;
		phase_d = phase_q;
		wait_d  = wait_q;
		code_d  = code_q;
		split   = 1'b0;
		low_d   = low_q;
		high_d  = high_q;
		unique case (phase_q)
			PH_ROW_CONF, PH_BTN_CONF: begin
				wait_d = wait_done ? 8'd0 : wait_inc;
				if (wait_done) begin
					if (phase_q == PH_ROW_CONF ? !rows_idle : !btns_idle) begin
						code_d  = (phase_q == PH_ROW_CONF) ? row_code : btn_code;
						split   = 1'b1;
						phase_d = (phase_q == PH_ROW_CONF) ? PH_ROW_HOLD : PH_BTN_HOLD;
					end else begin
						col_d   = col_q + COL_W'(1);
						phase_d = PH_SETTLE;
					end
				end
			end
			PH_ROW_HOLD, PH_BTN_HOLD: begin
				wait_d = wait_done ? 8'd0 : wait_inc;
				if (wait_done) begin
					phase_d = (phase_q == PH_ROW_HOLD) ? PH_ROW_POLL : PH_BTN_POLL;
				end
			end
			PH_ROW_POLL, PH_BTN_POLL: begin
				if (phase_q == PH_ROW_POLL ? rows_idle : btns_idle) begin
					phase_d = (phase_q == PH_ROW_POLL) ? PH_ROW_REL : PH_BTN_REL;
					wait_d  = 8'd0;
				end
			end
			PH_ROW_REL, PH_BTN_REL: begin
				wait_d = wait_done ? 8'd0 : wait_inc;
				if (wait_done) begin
					if (phase_q == PH_ROW_REL ? rows_idle : btns_idle) begin
						low_d   = BLANK_DIGIT;
						high_d  = BLANK_DIGIT;
						col_d   = col_q + COL_W'(1);
						phase_d = PH_SETTLE;
					end else begin
						phase_d = (phase_q == PH_ROW_REL) ? PH_ROW_POLL : PH_BTN_POLL;
					end
				end
			end
			default: begin
				phase_d = PH_SETTLE;
				wait_d  = wait_done ? 8'd0 : wait_inc;
				if (wait_done) begin
					if (!rows_idle) begin
						phase_d = PH_ROW_CONF;
					end else if (!btns_idle) begin
						phase_d = PH_BTN_CONF;
					end else begin
						col_d = col_q + COL_W'(1);
					end
				end
			end
		endcase

		// split into decimal digits: q = code * 205 >> 11 is exact below 1029
		div_prod = 16'(code_d) * 16'd205;
		div_q    = div_prod[15:11];
		div_r    = code_d - ({3'd0, div_q} * 8'd10);
		if (split) begin
			low_d  = {1'b0, div_r[3:0]};
			high_d = div_q;
		end
	end

	// display refresh
	assign refresh_inc = refresh_q + 8'd1;

	always_comb begin
		refresh_d = refresh_inc;
		dphase_d  = dphase_q;
		seg_d     = seg_q;
		sel_d     = sel_q;
		if (refresh_inc >= refresh_cfg_q) begin
			refresh_d = 8'd0;
			dphase_d  = !dphase_q;
			seg_d     = dphase_q ? glyph(high_d) : glyph(low_d);
			sel_d     = dphase_q ? SEL_HIGH : SEL_LOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			col_q       <= '0;
			phase_q     <= PH_SETTLE;
			wait_q      <= 8'd0;
			code_q      <= 8'd0;
			low_q       <= BLANK_DIGIT;
			high_q      <= BLANK_DIGIT;
			refresh_q   <= 8'd0;
			dphase_q    <= 1'b0;
			seg_q       <= SEG_BLANK;
			sel_q       <= SEL_NONE;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				col_q       <= col_d;
				phase_q     <= phase_d;
				wait_q      <= wait_d;
				code_q      <= code_d;
				low_q       <= low_d;
				high_q      <= high_d;
				refresh_q   <= refresh_d;
				dphase_q    <= dphase_d;
				seg_q       <= seg_d;
				sel_q       <= sel_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign column_drive    = ~(8'd1 << col_q);
	assign segment_pattern = seg_q;
	assign digit_select    = sel_q;
	assign key_code        = code_q;
	assign key_held        = (phase_q == PH_ROW_HOLD) || (phase_q == PH_ROW_POLL) ||
	                         (phase_q == PH_ROW_REL)  || (phase_q == PH_BTN_HOLD) ||
	                         (phase_q == PH_BTN_POLL) || (phase_q == PH_BTN_REL);

endmodule

`default_nettype wire

@@ tb/keypad_scan_to_segment_display_tb.sv @@
// ----------------------------------------------------------------------------
// keypad_scan_to_segment_display_tb
// Self-checking bench for the keypad scanner with two-digit display. A tick
// driver and a result monitor run as clocked processes; every accepted tick
// is run through a cycle-free model of the scanner and the display refresh,
// and every result transfer is checked field by field against the oldest
// prediction. Register settings change between phases, only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_to_segment_display_tb;

	import kssd_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	localparam logic [7:0] ROWS_IDLE = 8'hFF;
	localparam logic [4:0] BTNS_IDLE = 5'h1F;

	localparam logic [7:0] GLYPHS [32] = '{
		8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F,
		8'h01, 8'h09, 8'hFF, 8'hFE, 8'h11, 8'hC1, 8'h63, 8'h85,
		8'h61, 8'h71, 8'h43, 8'h91, 8'hC3, 8'h83, 8'h73, 8'h13,
		8'h31, 8'h89, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	typedef struct packed {
		logic [7:0] rows;
		logic [4:0] buttons;
	} tick_t;

	typedef struct packed {
		logic [7:0] column_drive;
		logic [7:0] segment_pattern;
		logic [1:0] digit_select;
		logic [7:0] key_code;
		logic       key_held;
	} panel_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [31:0]       pwdata       = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [7:0]        main_rows    = ROWS_IDLE;
	logic [4:0]        button_lines = BTNS_IDLE;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [7:0]        column_drive;
	logic [7:0]        segment_pattern;
	logic [1:0]        digit_select;
	logic [7:0]        key_code;
	logic              key_held;

	// scanner model state
	logic [7:0] settle_reg;
	logic [7:0] refresh_reg;
	logic [2:0] m_column;
	phase_t     m_phase;
	logic [7:0] m_wait;
	logic [7:0] m_code;
	digit_t     m_low;
	digit_t     m_high;
	logic [7:0] m_refresh;
	logic       m_digit_phase;
	logic [7:0] m_seg;
	logic [1:0] m_sel;

	tick_t  tick_q[$];
	panel_t panel_q[$];

	int  errors      = 0;
	int  ticks_taken = 0;
	int  results     = 0;
	int  row_keys    = 0;
	int  button_keys = 0;
	int  releases    = 0;
	int  ticks_left  = 0;
	int  send_gap    = 0;
	int  recv_stall  = 0;
	int  quiet       = 0;
	int  calm_left [2] = '{0, 0};
	bit  pause_tx    = 1'b0;

	keypad_scan_to_segment_display i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.main_rows       (main_rows),
		.button_lines    (button_lines),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.column_drive    (column_drive),
		.segment_pattern (segment_pattern),
		.digit_select    (digit_select),
		.key_code        (key_code),
		.key_held        (key_held)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void reset_scanner();
		settle_reg    = SETTLE_RESET;
		refresh_reg   = REFRESH_RESET;
		m_column      = '0;
		m_phase       = PH_SETTLE;
		m_wait        = '0;
		m_code        = '0;
		m_low         = BLANK_DIGIT;
		m_high        = BLANK_DIGIT;
		m_refresh     = '0;
		m_digit_phase = 1'b0;
		m_seg         = SEG_BLANK;
		m_sel         = SEL_NONE;
	endfunction

	function automatic bit settle_elapsed();
		m_wait = m_wait + 8'd1;
		if (m_wait >= settle_reg) begin
			m_wait = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void step_column();
		m_column = m_column + 3'd1;
		m_phase  = PH_SETTLE;
		m_wait   = '0;
	endfunction

	function automatic int lone_bit(input logic [7:0] v, input int n);
		for (int i = 0; i < n; i++)
			if (v == (8'd1 << i))
				return i;
		return -1;
	endfunction

	function automatic void split_code();
		m_low  = digit_t'(m_code % 10);
		m_high = digit_t'(m_code / 10);
	endfunction

	function automatic panel_t advance_scanner(input logic [7:0] rows, input logic [4:0] btns);
		bit     rows_idle;
		bit     btns_idle;
		bit     idle;
		int     b;
		panel_t r;
		rows_idle = (rows == ROWS_IDLE);
		btns_idle = (btns == BTNS_IDLE);
		case (m_phase)
			PH_ROW_CONF: begin
				if (settle_elapsed()) begin
					if (!rows_idle) begin
						b = lone_bit(~rows & 8'h7F, 7);
						if (b >= 0)
							m_code = 8'(8 * b + 7);
						m_code = m_code - {5'd0, m_column};
						split_code();
						m_phase = PH_ROW_HOLD;
						row_keys++;
					end else begin
						step_column();
					end
				end
			end
			PH_BTN_CONF: begin
				if (settle_elapsed()) begin
					if (!btns_idle) begin
						b = lone_bit({3'd0, ~btns}, 5);
						if (b >= 0)
							m_code = 8'(8 * b);
						m_code = m_code + {5'd0, m_column} + BTN_OFFSET;
						split_code();
						m_phase = PH_BTN_HOLD;
						button_keys++;
					end else begin
						step_column();
					end
				end
			end
			PH_ROW_HOLD: begin
				if (settle_elapsed())
					m_phase = PH_ROW_POLL;
			end
			PH_BTN_HOLD: begin
				if (settle_elapsed())
					m_phase = PH_BTN_POLL;
			end
			PH_ROW_POLL: begin
				if (rows_idle) begin
					m_phase = PH_ROW_REL;
					m_wait  = '0;
				end
			end
			PH_BTN_POLL: begin
				if (btns_idle) begin
					m_phase = PH_BTN_REL;
					m_wait  = '0;
				end
			end
			PH_ROW_REL, PH_BTN_REL: begin
				if (settle_elapsed()) begin
					idle = (m_phase == PH_ROW_REL) ? rows_idle : btns_idle;
					if (idle) begin
						m_low  = BLANK_DIGIT;
						m_high = BLANK_DIGIT;
						step_column();
						releases++;
					end else begin
						m_phase = (m_phase == PH_ROW_REL) ? PH_ROW_POLL : PH_BTN_POLL;
					end
				end
			end
			default: begin
				m_phase = PH_SETTLE;
				if (settle_elapsed()) begin
					if (!rows_idle)
						m_phase = PH_ROW_CONF;
					else if (!btns_idle)
						m_phase = PH_BTN_CONF;
					else
						step_column();
				end
			end
		endcase

		m_refresh = m_refresh + 8'd1;
		if (m_refresh >= refresh_reg) begin
			m_refresh = '0;
			if (!m_digit_phase) begin
				m_seg = GLYPHS[m_low];
				m_sel = SEL_LOW;
			end else begin
				m_seg = GLYPHS[m_high];
				m_sel = SEL_HIGH;
			end
			m_digit_phase = !m_digit_phase;
		end

		r.column_drive    = ~(8'd1 << m_column);
		r.segment_pattern = m_seg;
		r.digit_select    = m_sel;
		r.key_code        = m_code;
		r.key_held        = (m_phase == PH_ROW_HOLD) || (m_phase == PH_ROW_POLL) ||
		                    (m_phase == PH_ROW_REL)  || (m_phase == PH_BTN_HOLD) ||
		                    (m_phase == PH_BTN_POLL) || (m_phase == PH_BTN_REL);
		return r;
	endfunction

	// side 0 is the tick sender, side 1 the result receiver
	function automatic int pick_pause(input int side);
		int r;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 63) == 0)
			calm_left[side] = $urandom_range(30, 120);
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		tick_t t;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (!pause_tx && tick_q.size() != 0) begin
				t = tick_q.pop_front();
				main_rows    <= t.rows;
				button_lines <= t.buttons;
				in_valid     <= 1'b1;
				send_gap = pick_pause(0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		panel_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results++;
				if (panel_q.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, actual %0h",
						$time, {column_drive, segment_pattern, digit_select, key_code, key_held});
					errors++;
				end else begin
					want = panel_q.pop_front();
					compare_field("column_drive", want.column_drive, column_drive);
					compare_field("segment_pattern", want.segment_pattern, segment_pattern);
					compare_field("digit_select", {6'd0, want.digit_select}, {6'd0, digit_select});
					compare_field("key_code", want.key_code, key_code);
					compare_field("key_held", {7'd0, want.key_held}, {7'd0, key_held});
				end
			end
			if (in_valid && in_ready) begin
				panel_q.push_back(advance_scanner(main_rows, button_lines));
				ticks_taken++;
			end
		end
		if (recv_stall != 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			recv_stall = pick_pause(1);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet);
				$display("keypad_scan_to_segment_display test failed");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic idx, input logic [7:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_SETTLE)
			settle_reg = val;
		else
			refresh_reg = val;
	endtask

	task automatic drain_all();
		do
			@(negedge clk);
		while (in_valid || tick_q.size() != 0 || panel_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic void push_tick(input logic [7:0] rows, input logic [4:0] btns);
		if (ticks_left > 0) begin
			tick_q.push_back('{rows, btns});
			ticks_left--;
		end
	endfunction

	function automatic logic [7:0] pick_rows();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return ~(8'd1 << $urandom_range(0, 6));
		if (r == 7)
			return 8'h7F;
		if (r == 8)
			return ~((8'd1 << $urandom_range(0, 7)) | (8'd1 << $urandom_range(0, 7)));
		return 8'($urandom);
	endfunction

	function automatic logic [4:0] pick_buttons();
		if ($urandom_range(0, 9) < 8)
			return ~(5'd1 << $urandom_range(0, 4));
		return 5'($urandom_range(0, 30));
	endfunction

	// one press-and-release, a bounce burst or plain noise, scaled to the settle time
	function automatic void add_episode(input int s);
		int         kind;
		int         n;
		int         glitch;
		bit         on_buttons;
		logic [7:0] rp;
		logic [4:0] bp;
		kind       = $urandom_range(0, 9);
		on_buttons = (kind == 6 || kind == 7);
		rp         = pick_rows();
		bp         = pick_buttons();
		if (kind <= 7) begin
			n = $urandom_range(0, 2 * s);
			repeat (n) push_tick(ROWS_IDLE, BTNS_IDLE);
			n = $urandom_range(2 * s, 5 * s + 3);
			repeat (n) begin
				if (on_buttons)
					push_tick(ROWS_IDLE, bp);
				else
					push_tick(rp, $urandom_range(0, 1) ? 5'($urandom) : BTNS_IDLE);
			end
			n      = $urandom_range(s, 3 * s + 2);
			glitch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
			for (int i = 0; i < n; i++) begin
				if (i == glitch)
					push_tick(on_buttons ? ROWS_IDLE : rp, on_buttons ? bp : BTNS_IDLE);
				else
					push_tick(ROWS_IDLE, BTNS_IDLE);
			end
		end else if (kind == 8) begin
			n = $urandom_range(s, 4 * s + 2);
			repeat (n)
				push_tick($urandom_range(0, 1) ? rp : ROWS_IDLE,
				          $urandom_range(0, 1) ? bp : BTNS_IDLE);
		end else begin
			n = $urandom_range(1, s + 3);
			repeat (n) push_tick(8'($urandom), 5'($urandom));
		end
	endfunction

	task automatic run_phase(input logic [7:0] settle, input logic [7:0] refresh,
	                         input int budget, input bit with_hold);
		int s;
		drain_all();
		reg_write(REG_SETTLE, settle);
		reg_write(REG_REFRESH, refresh);
		@(negedge clk);
		s = (settle == 0) ? 1 : int'(settle);
		ticks_left = budget;
		while (ticks_left > 0)
			add_episode(s);
		if (with_hold) begin
			do
				@(negedge clk);
			while (tick_q.size() > budget / 2);
			// hold the sender until every prediction is matched
			pause_tx = 1'b1;
			do
				@(negedge clk);
			while (in_valid || panel_q.size() != 0);
			repeat (3) @(negedge clk);
			pause_tx = 1'b0;
		end
	endtask

	initial begin
		reset_scanner();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		reg_write(REG_SETTLE, 8'd1);
		reg_write(REG_REFRESH, 8'd1);
		@(negedge clk);
		ticks_left = 25;
		// single row key, lone button, all rows low, row bit 7 alone, all buttons low
		repeat (3) push_tick(8'hFE, BTNS_IDLE);
		repeat (2) push_tick(ROWS_IDLE, BTNS_IDLE);
		repeat (3) push_tick(ROWS_IDLE, 5'h0F);
		repeat (2) push_tick(ROWS_IDLE, BTNS_IDLE);
		repeat (3) push_tick(8'h00, 5'h00);
		repeat (2) push_tick(ROWS_IDLE, BTNS_IDLE);
		repeat (3) push_tick(8'h7F, BTNS_IDLE);
		repeat (2) push_tick(ROWS_IDLE, BTNS_IDLE);
		repeat (3) push_tick(ROWS_IDLE, 5'h00);
		repeat (2) push_tick(ROWS_IDLE, BTNS_IDLE);

		run_phase(8'd2, 8'd3, 160, 1'b1);
		run_phase(8'd1, 8'd255, 120, 1'b0);
		run_phase(8'd0, 8'd0, 60, 1'b0);
		run_phase(8'd5, 8'd1, 100, 1'b0);
		run_phase(8'd255, 8'd9, 650, 1'b0);
		drain_all();
		repeat (4) @(posedge clk);

		$display("Covered %0d ticks and %0d results over six settle/refresh settings (0, 1, 255).",
			ticks_taken, results);
		$display("Confirmed %0d row keys and %0d buttons, %0d releases; %0d errors.",
			row_keys, button_keys, releases, errors);
		if (errors == 0)
			$display("keypad_scan_to_segment_display test passed");
		else
			$display("keypad_scan_to_segment_display test failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
rtl/kssd_pkg.sv
rtl/keypad_scan_to_segment_display.sv
tb/keypad_scan_to_segment_display_tb.sv
